// ----- src/assert_macros.svh -----
// Assertion macros used by the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that a property holds at every rising clock edge outside reset.
`define BDA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("Assertion failed.");

// Checks that a condition never occurs outside reset.
`define BDA_ASSERT_NEVER(label, clk, rst_n, cond) \
  `BDA_ASSERT(label, clk, rst_n, !(cond))

`else

`define BDA_ASSERT(label, clk, rst_n, prop)
`define BDA_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- src/bda_pkg.sv -----
`default_nettype none

package bda_pkg;

  localparam int VALUE_BITS = 32;
  // Decimal digits needed for VALUE_BITS bits, using log10(2) ~ 0.30103.
  localparam int DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W      = DIGITS * 4;
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int DCNT_W     = $clog2(DIGITS + 1);
  localparam int CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_TRIM,
    S_EMIT
  } bda_state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic skip;
    logic emit;
  } bda_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic one_left;
    logic out_free;
  } bda_status_t;

endpackage

`default_nettype wire

// ----- src/bda_dp.sv -----
`default_nettype none

module bda_dp (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  bda_pkg::bda_cmd_t                  cmd_i,
  output bda_pkg::bda_status_t               status_o,
  input  wire [bda_pkg::VALUE_BITS-1:0]      value_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [bda_pkg::CHAR_W-1:0]         digit_char_o,
  output logic                               last_digit_o
);
  import bda_pkg::*;

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d, bcd_adj;
  logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [DCNT_W-1:0]     dcnt_q, dcnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     char_q, char_d;
  logic                  last_q, last_d;
  logic [3:0]            top_digit;

  assign top_digit = bcd_q[BCD_W-1 -: 4];

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    dcnt_d      = dcnt_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.load) begin
      bin_d     = value_i;
      bcd_d     = '0;
      bit_cnt_d = '0;
      dcnt_d    = DCNT_W'(DIGITS);
    end

    if (cmd_i.shift) begin
      {bcd_d, bin_d} = {bcd_adj, bin_q} << 1;
      bit_cnt_d      = bit_cnt_q + BIT_CNT_W'(1);
    end

    if (cmd_i.skip) begin
      bcd_d  = bcd_q << 4;
      dcnt_d = dcnt_q - DCNT_W'(1);
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      char_d      = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, top_digit};
      last_d      = (dcnt_q == DCNT_W'(1));
      bcd_d       = bcd_q << 4;
      dcnt_d      = dcnt_q - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
      dcnt_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
      dcnt_q      <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign status_o.conv_done = (bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1));
  assign status_o.top_zero  = (top_digit == 4'd0);
  assign status_o.one_left  = (dcnt_q == DCNT_W'(1));
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

endmodule

`default_nettype wire

// ----- src/bda_ctrl.sv -----
`default_nettype none

module bda_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  bda_pkg::bda_status_t  status_i,
  output bda_pkg::bda_cmd_t     cmd_o
);
  import bda_pkg::*;

  bda_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.shift = 1'b1;
        if (status_i.conv_done) begin
          state_d = S_TRIM;
        end
      end
      S_TRIM: begin
        // Drop leading zero digits but always keep the last one.
        if (status_i.top_zero && !status_i.one_left) begin
          cmd_o.skip = 1'b1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.one_left) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/binary_to_decimal_ascii.sv -----
// Converts an unsigned 32-bit value into its decimal ASCII digits.
// The input channel takes one value per beat (value_i); the output channel
// gives one digit character per beat, most significant first, with leading
// zeros dropped, and last_digit_o set on the final digit. Zero gives "0".
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low.
// A value is accepted, then runs 32 shift-add-3 steps in the shared
// conversion datapath, drops its leading zeros one digit at a time and
// finally emits its n digits, most significant first.
// One value is worked on at a time; in_stall_o is high while it is.
// A stall on the output holds the current digit and freezes the emission;
// the last digit can wait in the output register while the next value is
// already accepted.
// Reset clears the controller and the output valid; no clearing pass.
`default_nettype none

module binary_to_decimal_ascii (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire [bda_pkg::VALUE_BITS-1:0]   value_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [bda_pkg::CHAR_W-1:0]      digit_char_o,
  output logic                            last_digit_o
);
  import bda_pkg::*;

  `include "assert_macros.svh"

  bda_cmd_t    cmd;
  bda_status_t status;
  logic        char_bad;

  bda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bda_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

  assign char_bad = (digit_char_o < ASCII_ZERO) ||
                    (digit_char_o > (ASCII_ZERO + CHAR_W'(9)));

  `BDA_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `BDA_ASSERT_NEVER(a_char_range, clk_i, rst_ni, out_valid_o && char_bad)
  `BDA_ASSERT_NEVER(a_one_cmd, clk_i, rst_ni, !$onehot0({cmd.load, cmd.shift, cmd.skip, cmd.emit}))

endmodule

`default_nettype wire
